[design/sgf_pkg.sv]
// shared types, constants and arithmetic helpers of the scharr gradient filter
package sgf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int PIXEL_W        = 8;
    localparam int GRAD_W         = 13;
    localparam int SMOOTH_W       = 12;
    localparam int DIFF_W         = 9;
    localparam int CFG_WIDTH_W    = 11;
    localparam int CFG_HEIGHT_W   = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int ROW_W          = 13;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [SMOOTH_W-1:0]      smooth;
        logic signed [DIFF_W-1:0] diff;
        logic                     emit_mid;
        logic                     col_is_one;
        logic                     emit_last;
        logic                     wide;
        logic                     frame_end;
    } t_entry;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic                     frame_end;
    } t_result;

    // 3*(up+down) + 10*mid
    function automatic logic [SMOOTH_W-1:0] smooth_calc(
        input logic [PIXEL_W-1:0] up,
        input logic [PIXEL_W-1:0] mid,
        input logic [PIXEL_W-1:0] down
    );
        logic [SMOOTH_W-1:0] sum_ud;
        logic [SMOOTH_W-1:0] mid_x;
        sum_ud = SMOOTH_W'(up) + SMOOTH_W'(down);
        mid_x  = SMOOTH_W'(mid);
        return (sum_ud << 1) + sum_ud + (mid_x << 3) + (mid_x << 1);
    endfunction

    // 3*(left+right) + 10*centre
    function automatic logic signed [GRAD_W-1:0] grad_y_calc(
        input logic signed [DIFF_W-1:0] dl,
        input logic signed [DIFF_W-1:0] dc,
        input logic signed [DIFF_W-1:0] dr
    );
        logic signed [GRAD_W:0] sum_lr;
        logic signed [GRAD_W:0] centre;
        logic signed [GRAD_W:0] total;
        sum_lr = (GRAD_W+1)'(dl) + (GRAD_W+1)'(dr);
        centre = (GRAD_W+1)'(dc);
        total  = (sum_lr <<< 1) + sum_lr + (centre <<< 3) + (centre <<< 1);
        return total[GRAD_W-1:0];
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad_x_calc(
        input logic [SMOOTH_W-1:0] sl,
        input logic [SMOOTH_W-1:0] sr
    );
        logic signed [GRAD_W-1:0] diff;
        diff = $signed({1'b0, sr}) - $signed({1'b0, sl});
        return diff;
    endfunction

endpackage

[design/sgf_front.sv]
// front end: frame counters, row store and vertical (column) filter
module sgf_front #(
    parameter int MAX_WIDTH = sgf_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [sgf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [sgf_pkg::PIXEL_W-1:0]   i_pixel,
    output logic                          o_push,
    output sgf_pkg::t_entry               o_entry,
    input  logic                          i_full
);
    import sgf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam logic [CW-1:0] RST_WM1 = CW'(RST_W - 1);
    localparam logic [CW-1:0] COL_ONE = CW'(1);
    localparam logic [ROW_W-1:0] ROW_ONE = ROW_W'(1);
    localparam logic [ROW_W-1:0] ROW_TWO = ROW_W'(2);

    logic [CW-1:0]    r_wm1;
    logic [ROW_W-1:0] r_h;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic [2*PIXEL_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIXEL_W-1:0] r_rd;
    logic                 r_byp;
    logic [2*PIXEL_W-1:0] r_byp_data;

    logic               r_s1_valid;
    logic [PIXEL_W-1:0] r_s1_pixel;
    logic               r_s1_flush;
    logic [CW-1:0]      r_s1_col;
    logic               r_s1_up_mem;
    logic               r_s1_emit_mid;
    logic               r_s1_col_is1;
    logic               r_s1_emit_last;
    logic               r_s1_wide;

    logic               flush_phase;
    logic               accept;
    logic               load;
    logic               advance;
    logic               col_last;
    logic [31:0]        cfg_w;
    logic [31:0]        cfg_h;
    logic [CW-1:0]      n_wm1;
    logic [ROW_W-1:0]   n_h;
    logic [2*PIXEL_W-1:0] rd_eff;
    logic [2*PIXEL_W-1:0] wr_data;
    logic [PIXEL_W-1:0] up;
    logic [PIXEL_W-1:0] mid;
    logic [PIXEL_W-1:0] down;

    assign flush_phase = (r_row >= r_h);
    assign advance     = r_s1_valid && !i_full;
    assign o_ready     = !r_s1_valid || !i_full;
    assign accept      = i_valid && o_ready;
    assign load        = accept && ((i_op == OP_FLUSH) == flush_phase);
    assign col_last    = (r_col == r_wm1);

    always_comb begin
        cfg_w = 32'(i_cfg_wdata[CFG_WIDTH_W-1:0]);
        cfg_h = 32'(i_cfg_wdata[CFG_HEIGHT_W-1:0]);
        if (cfg_w == 32'd0) begin
            n_wm1 = '0;
        end else if (cfg_w > 32'(MAX_WIDTH)) begin
            n_wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            n_wm1 = CW'(cfg_w - 32'd1);
        end
        if (cfg_h == 32'd0) begin
            n_h = ROW_ONE;
        end else if (cfg_h > 32'(MAX_HEIGHT)) begin
            n_h = ROW_W'(MAX_HEIGHT);
        end else begin
            n_h = ROW_W'(cfg_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= RST_WM1;
            r_h   <= ROW_W'(RESET_HEIGHT);
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WIDTH:  r_wm1 <= n_wm1;
                REG_HEIGHT: r_h   <= n_h;
                default:    r_h   <= r_h;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (load) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= flush_phase ? '0 : r_row + ROW_ONE;
            end else begin
                r_col <= r_col + COL_ONE;
            end
        end
    end

    // row store: older row in the upper byte, newer row in the lower byte
    assign rd_eff  = r_byp ? r_byp_data : r_rd;
    assign wr_data = {rd_eff[PIXEL_W-1:0], r_s1_pixel};

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rd       <= r_mem[r_col];
            r_byp_data <= wr_data;
        end
        if (advance && !r_s1_flush) begin
            r_mem[r_s1_col] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (load) begin
            r_byp <= advance && !r_s1_flush && (r_s1_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= load || (r_s1_valid && !advance);
        end
        if (load) begin
            r_s1_pixel     <= i_pixel;
            r_s1_flush     <= flush_phase;
            r_s1_col       <= r_col;
            r_s1_up_mem    <= (r_row >= ROW_TWO);
            r_s1_emit_mid  <= (r_row >= ROW_ONE) && (r_col != '0);
            r_s1_col_is1   <= (r_col == COL_ONE);
            r_s1_emit_last <= (r_row >= ROW_ONE) && col_last;
            r_s1_wide      <= (r_wm1 != '0);
        end
    end

    always_comb begin
        mid = rd_eff[PIXEL_W-1:0];
        if (r_s1_flush) begin
            up   = (r_h != ROW_ONE) ? rd_eff[2*PIXEL_W-1:PIXEL_W] : mid;
            down = up;
        end else begin
            up   = r_s1_up_mem ? rd_eff[2*PIXEL_W-1:PIXEL_W] : r_s1_pixel;
            down = r_s1_pixel;
        end
        o_entry.smooth     = smooth_calc(up, mid, down);
        o_entry.diff       = $signed({1'b0, down}) - $signed({1'b0, up});
        o_entry.emit_mid   = r_s1_emit_mid;
        o_entry.col_is_one = r_s1_col_is1;
        o_entry.emit_last  = r_s1_emit_last;
        o_entry.wide       = r_s1_wide;
        o_entry.frame_end  = r_s1_flush;
    end

    assign o_push = advance;

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_wm1)
        else $error("column counter past row end");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && i_full) |=> (r_s1_valid && $stable(r_s1_col)))
        else $error("stalled front stage lost its item");
`endif

endmodule

[design/sgf_queue.sv]
// small queue between the column filter and the row filter
module sgf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sgf_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output sgf_pkg::t_entry o_data,
    output logic            o_empty
);
    import sgf_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

[design/sgf_back.sv]
// back end: horizontal window, gradient results and output register
module sgf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sgf_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output sgf_pkg::t_result o_result
);
    import sgf_pkg::*;

    logic [SMOOTH_W-1:0]      r_sm_a;
    logic [SMOOTH_W-1:0]      r_sm_b;
    logic signed [DIFF_W-1:0] r_df_a;
    logic signed [DIFF_W-1:0] r_df_b;

    t_result r_out;
    logic    r_out_valid;
    t_result r_pend;
    logic    r_pend_valid;

    logic                     slot_free;
    logic                     quiet;
    logic [SMOOTH_W-1:0]      sl;
    logic signed [DIFF_W-1:0] dl;
    logic signed [DIFF_W-1:0] dn;
    t_result                  res_mid;
    t_result                  res_last;

    // an entry that gives no result only moves the window
    assign quiet     = !i_entry.emit_mid && !i_entry.emit_last;
    assign slot_free = !r_out_valid || i_ready;
    assign o_pop     = !i_empty && (quiet || (!r_pend_valid && slot_free));

    always_comb begin
        sl = i_entry.col_is_one ? i_entry.smooth : r_sm_a;
        dl = i_entry.col_is_one ? i_entry.diff : r_df_a;
        dn = i_entry.wide ? r_df_b : i_entry.diff;
        res_mid.grad_x    = grad_x_calc(sl, i_entry.smooth);
        res_mid.grad_y    = grad_y_calc(dl, r_df_b, i_entry.diff);
        res_mid.frame_end = 1'b0;
        // mirrored right neighbour equals the left one
        res_last.grad_x    = '0;
        res_last.grad_y    = grad_y_calc(dn, i_entry.diff, dn);
        res_last.frame_end = i_entry.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_a <= '0;
            r_sm_b <= '0;
            r_df_a <= '0;
            r_df_b <= '0;
        end else if (o_pop) begin
            r_sm_a <= r_sm_b;
            r_sm_b <= i_entry.smooth;
            r_df_a <= r_df_b;
            r_df_b <= i_entry.diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (slot_free) begin
            if (r_pend_valid) begin
                r_out        <= r_pend;
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (o_pop && i_entry.emit_mid) begin
                r_out        <= res_mid;
                r_out_valid  <= 1'b1;
                r_pend       <= res_last;
                r_pend_valid <= i_entry.emit_last;
            end else if (o_pop && i_entry.emit_last) begin
                r_out       <= res_last;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("pending result without output in front of it");
`endif

endmodule

[design/scharr_gradient_filter_core.sv]
// scharr 3x3 gradient filter core: top level
// Raster-order 8-bit pixels come in on the slave stream (tuser high marks a flush
// tick); after the last row of a frame, one row of flush ticks (image_width of
// them) drains the last output row. For each accepted item the front end reads
// and writes a combined two-row line store (one read and one write port,
// depth MAX_WIDTH) and forms the column sums, a four-entry queue decouples it from
// the back end, which forms grad_x/grad_y and holds one output register plus one
// pending result. Results for row r appear while row r+1 arrives; a result passes
// the front stage, the queue and the output register, and the second result at the
// end of a row follows from the pending register while the back end takes the next
// column, which gives none. The input keeps one pixel per clock as long as the
// output is taken every cycle; output stalls back up through the queue. Writing
// either register restarts the frame and must happen while the block is idle.
module scharr_gradient_filter_core #(
    parameter int MAX_WIDTH = sgf_pkg::DEF_MAX_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [sgf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // pixel
    input  logic                           s_axis_tuser,  // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // grad_x, grad_y, zero fill
    output logic                           m_axis_tlast   // frame_end
);
    import sgf_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_entry  front_entry;
    t_entry  queue_entry;
    t_result result;

    sgf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_pixel     (s_axis_tdata),
        .o_push      (push),
        .o_entry     (front_entry),
        .i_full      (full)
    );

    sgf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_entry),
        .o_empty (empty)
    );

    sgf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (queue_entry),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {6'b0, result.grad_y, result.grad_x};
    assign m_axis_tlast = result.frame_end;

endmodule

[dv/testbench.sv]
// testbench of the scharr gradient filter core: streamed frames checked against a predictor
`timescale 1ns / 1ps

module testbench;
    import sgf_pkg::*;

    localparam int SIDE_TAP   = 3;
    localparam int CENTRE_TAP = 10;
    localparam int DRAIN_WAIT = 12;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic                  i_cfg_addr    = REG_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;  // pixel
    logic                  s_axis_tuser  = OP_PIXEL;  // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;  // grad_x, grad_y, zero fill
    logic                  m_axis_tlast;  // frame_end

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;

    // predictor state
    int unsigned cfg_width  = RESET_WIDTH;
    int unsigned cfg_height = RESET_HEIGHT;
    bit [7:0]    older_row [DEF_MAX_WIDTH];
    bit [7:0]    newer_row [DEF_MAX_WIDTH];
    int          smooth_win [3];
    int          diff_win [3];
    int          col_cnt = 0;
    int          row_cnt = 0;

    t_result grad_expect_q [$];
    t_result grad_front;

    scharr_gradient_filter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int frame_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int frame_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cfg_height;
    endfunction

    function automatic void push_gradient(int sl, int sr, int dl, int dc, int dr, bit last);
        t_result r;
        int      gx;
        int      gy;
        gx = sr - sl;
        gy = SIDE_TAP * (dl + dr) + CENTRE_TAP * dc;
        r.grad_x    = gx[GRAD_W-1:0];
        r.grad_y    = gy[GRAD_W-1:0];
        r.frame_end = last;
        grad_expect_q.push_back(r);
    endfunction

    function automatic void predict_gradients(logic op, logic [7:0] pix);
        int w;
        int h;
        int c;
        int up;
        int mid;
        int down;
        int sc;
        int dcur;
        bit flushing;
        w = frame_width();
        h = frame_height();
        flushing = (row_cnt >= h);
        if ((op == OP_FLUSH) != flushing) return;
        c = (col_cnt >= w) ? w - 1 : col_cnt;
        mid = newer_row[c];
        if (flushing) begin
            up   = (h > 1) ? older_row[c] : mid;
            down = up;
        end else begin
            up   = (row_cnt >= 2) ? older_row[c] : pix;
            down = pix;
            older_row[c] = newer_row[c];
            newer_row[c] = pix;
        end
        smooth_win[0] = smooth_win[1];
        smooth_win[1] = smooth_win[2];
        smooth_win[2] = SIDE_TAP * (up + down) + CENTRE_TAP * mid;
        diff_win[0]   = diff_win[1];
        diff_win[1]   = diff_win[2];
        diff_win[2]   = down - up;
        if (row_cnt >= 1) begin
            sc   = smooth_win[2];
            dcur = diff_win[2];
            if (c >= 1) begin
                push_gradient((c == 1) ? sc : smooth_win[0], sc,
                              (c == 1) ? dcur : diff_win[0], diff_win[1], dcur, 1'b0);
            end
            // right border reflects the column to its left
            if (c == w - 1) begin
                push_gradient((w > 1) ? smooth_win[1] : sc, (w > 1) ? smooth_win[1] : sc,
                              (w > 1) ? diff_win[1] : dcur, dcur,
                              (w > 1) ? diff_win[1] : dcur, flushing);
            end
        end
        if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = flushing ? 0 : row_cnt + 1;
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (grad_expect_q.size() == 0) begin
                $error("unexpected result transfer: grad_x %0d grad_y %0d frame_end %0b",
                       $signed(m_axis_tdata[GRAD_W-1:0]),
                       $signed(m_axis_tdata[2*GRAD_W-1:GRAD_W]), m_axis_tlast);
                err_count++;
            end else begin
                grad_front = grad_expect_q.pop_front();
                if (m_axis_tdata[GRAD_W-1:0] !== grad_front.grad_x) begin
                    $error("grad_x: expected %0d, actual %0d", grad_front.grad_x,
                           $signed(m_axis_tdata[GRAD_W-1:0]));
                    err_count++;
                end
                if (m_axis_tdata[2*GRAD_W-1:GRAD_W] !== grad_front.grad_y) begin
                    $error("grad_y: expected %0d, actual %0d", grad_front.grad_y,
                           $signed(m_axis_tdata[2*GRAD_W-1:GRAD_W]));
                    err_count++;
                end
                if (m_axis_tlast !== grad_front.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", grad_front.frame_end,
                           m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    task automatic send_item(input logic op, input logic [7:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_gradients(op, pix);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (grad_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // both registers are written back to back; either write restarts the frame
    task automatic set_frame_size(input int width_val, input int height_val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_WIDTH;
        i_cfg_wdata <= width_val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_width   = width_val & 'h7FF;
        col_cnt     = 0;
        row_cnt     = 0;
        i_cfg_addr  <= REG_HEIGHT;
        i_cfg_wdata <= height_val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        cfg_height  = height_val & 'h1FFF;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_frame(input bit abandon, input int pause_at, inout int sent);
        int          n_pix;
        int          stop;
        logic [7:0]  p;
        n_pix = frame_width() * frame_height();
        stop  = abandon ? $urandom_range(n_pix + frame_width() - 1) : n_pix + frame_width();
        for (int k = 0; k < stop; k++) begin
            if (k == pause_at) wait_drained();
            if (k < n_pix) begin
                if ($urandom_range(99) < 3) send_item(OP_FLUSH, 8'($urandom));
                p = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                             : 8'($urandom);
                send_item(OP_PIXEL, p);
            end else begin
                if ($urandom_range(99) < 3) send_item(OP_PIXEL, 8'($urandom));
                send_item(OP_FLUSH, 8'($urandom));
            end
            sent++;
        end
    endtask

    task automatic test_directed_frames();
        bit [7:0] pattern [9] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd255,
                                  8'd255, 8'd255, 8'd255};
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        set_frame_size(3, 3);
        send_item(OP_FLUSH, 8'hFF);  // early flush is dropped
        foreach (pattern[k]) send_item(OP_PIXEL, pattern[k]);
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_PIXEL, 8'hAA);  // pixel inside the flush row is dropped
        send_item(OP_FLUSH, 8'h55);
        send_item(OP_FLUSH, 8'hFF);
        wait_drained();
        // zero registers act as a one-pixel frame
        set_frame_size(0, 0);
        send_item(OP_PIXEL, 8'h5A);
        send_item(OP_FLUSH, 8'h00);
        wait_drained();
        set_frame_size(2, 1);
        send_item(OP_PIXEL, 8'hFF);
        send_item(OP_PIXEL, 8'h00);
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_FLUSH, 8'h00);
        wait_drained();
    endtask

    // oversized registers act as the largest frame; a full row and a bit of the next
    task automatic test_size_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_frame_size(2047, 8191);
        for (int k = 0; k < DEF_MAX_WIDTH + 40; k++) send_item(OP_PIXEL, 8'($urandom));
        wait_drained();
    endtask

    task automatic test_random_frames(input int send_pct, input int stall_pct, input int n_items);
        int sent;
        int w_reg;
        int h_reg;
        int frames;
        int r;
        bit paused;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            w_reg = (r < 5) ? 0 : (r < 75) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            h_reg = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 5);
            wait_drained();
            set_frame_size(w_reg, h_reg);
            frames = $urandom_range(1, 2);
            for (int f = 0; f < frames; f++) begin
                run_frame((f == frames - 1) && ($urandom_range(9) == 0),
                          paused ? -1 : $urandom_range(frame_width() * (frame_height() + 1) - 1),
                          sent);
                paused = 1'b1;
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_size_extremes();
        test_random_frames(0, 0, 90);
        test_random_frames(60, 0, 90);
        test_random_frames(0, 60, 90);
        test_random_frames(36, 36, 90);
        wait_drained();
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[scharr_gradient_filter_core.f]
design/sgf_pkg.sv
design/sgf_front.sv
design/sgf_queue.sv
design/sgf_back.sv
design/scharr_gradient_filter_core.sv
dv/testbench.sv
